// ===== sv/assert_macros.svh =====
// Assertion macros for the checker in tapp_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons holds in the cycle where ante holds
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed in same cycle");

// cons holds in the cycle after ante holds
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed in next cycle");

`endif

// ===== sv/tapp_pkg.sv =====
// Shared constants, codes and command/status types of the three-axis PID controller.
package tapp_pkg;

  localparam int unsigned AXES       = 3;
  localparam int unsigned AXIS_W     = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned DT_W       = 16;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned INT_W      = 48;
  localparam int unsigned QUO_W      = POS_W + FRAC_W;
  localparam int unsigned DER_W      = QUO_W + 1;
  localparam int unsigned SPLIT_W    = 32;
  localparam int unsigned OPD_W      = SPLIT_W + 1;
  localparam int unsigned PROD_W     = 2 * OPD_W;
  localparam int unsigned ACC_W      = 84;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned DIV_CNT_W  = $clog2(QUO_W + 1);

  localparam logic [AXIS_W-1:0]    LAST_AXIS = AXIS_W'(AXES - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(QUO_W);

  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
  localparam logic [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP = 2'd0,
    REG_KI = 2'd1,
    REG_KD = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    MUL_E_DT   = 3'd0,
    MUL_KP_E   = 3'd1,
    MUL_KI_ILO = 3'd2,
    MUL_KI_IHI = 3'd3,
    MUL_KD_DLO = 3'd4,
    MUL_KD_DHI = 3'd5,
    MUL_CTL_DT = 3'd6
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD   = 2'd0,
    ACC_CLEAR  = 2'd1,
    ACC_ADD_LO = 2'd2,
    ACC_ADD_HI = 2'd3
  } acc_op_e;

  typedef struct packed {
    mul_sel_e          mul_sel;
    acc_op_e           acc_op;
    logic              latch_in;
    logic              calc_err;
    logic              start_div;
    logic              update_state;
    logic              load_d;
    logic              calc_ctl;
    logic              store_res;
    logic              load_out;
    logic [AXIS_W-1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } stat_t;

endpackage

// ===== sv/tapp_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module tapp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tapp_pkg::QUO_W-1:0] dividend_i,
  input  logic [tapp_pkg::DT_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [tapp_pkg::QUO_W-1:0] quotient_o
);

  logic                           busy_q, busy_d;
  logic [tapp_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [tapp_pkg::QUO_W-1:0]     quo_q, quo_d;
  logic [tapp_pkg::DT_W-1:0]      rem_q, rem_d;
  logic [tapp_pkg::DT_W-1:0]      dvs_q, dvs_d;
  logic [tapp_pkg::DT_W:0]        rem_sh;
  logic [tapp_pkg::DT_W+1:0]      trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q, quo_q[tapp_pkg::QUO_W-1]};
    trial  = {1'b0, rem_sh} - {2'b00, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = tapp_pkg::DIV_STEPS;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[tapp_pkg::DT_W+1]) begin
        rem_d = trial[tapp_pkg::DT_W-1:0];
        quo_d = {quo_q[tapp_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[tapp_pkg::DT_W-1:0];
        quo_d = {quo_q[tapp_pkg::QUO_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == tapp_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/tapp_dpath.sv =====
// Datapath: gains, per-axis state, shared multiplier, accumulator and result registers.
module tapp_dpath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tapp_pkg::cmd_t                        cmd_i,
  output tapp_pkg::stat_t                       stat_o,
  input  logic                                  cfg_we_i,
  input  logic [tapp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [tapp_pkg::GAIN_W-1:0]           cfg_data_i,
  input  logic signed [tapp_pkg::POS_W-1:0]     setpoint_x_i,
  input  logic signed [tapp_pkg::POS_W-1:0]     setpoint_y_i,
  input  logic signed [tapp_pkg::POS_W-1:0]     setpoint_z_i,
  input  logic signed [tapp_pkg::POS_W-1:0]     measured_x_i,
  input  logic signed [tapp_pkg::POS_W-1:0]     measured_y_i,
  input  logic signed [tapp_pkg::POS_W-1:0]     measured_z_i,
  input  logic [tapp_pkg::DT_W-1:0]             tick_time_i,
  output logic signed [tapp_pkg::POS_W-1:0]     control_x_o,
  output logic signed [tapp_pkg::POS_W-1:0]     control_y_o,
  output logic signed [tapp_pkg::POS_W-1:0]     control_z_o,
  output logic signed [tapp_pkg::POS_W-1:0]     offset_x_o,
  output logic signed [tapp_pkg::POS_W-1:0]     offset_y_o,
  output logic signed [tapp_pkg::POS_W-1:0]     offset_z_o
);

  logic [tapp_pkg::GAIN_W-1:0] kp_q, ki_q, kd_q;
  logic [tapp_pkg::POS_W-1:0]  sp_q  [tapp_pkg::AXES];
  logic [tapp_pkg::POS_W-1:0]  ms_q  [tapp_pkg::AXES];
  logic [tapp_pkg::DT_W-1:0]   dt_q;
  logic [tapp_pkg::INT_W-1:0]  integ_q [tapp_pkg::AXES];
  logic [tapp_pkg::POS_W-1:0]  prev_q  [tapp_pkg::AXES];
  logic [tapp_pkg::POS_W-1:0]  err_q, err_d;
  logic                        neg_q;
  logic [tapp_pkg::DER_W-1:0]  der_q, der_d;
  logic [tapp_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [tapp_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [tapp_pkg::POS_W-1:0]  ctl_q, ctl_d;
  logic [tapp_pkg::POS_W-1:0]  ctl_res_q [tapp_pkg::AXES];
  logic [tapp_pkg::POS_W-1:0]  off_res_q [tapp_pkg::AXES];
  logic [tapp_pkg::POS_W-1:0]  ctl_out_q [tapp_pkg::AXES];
  logic [tapp_pkg::POS_W-1:0]  off_out_q [tapp_pkg::AXES];

  logic [tapp_pkg::POS_W-1:0]  sp_sel, ms_sel, prev_sel;
  logic [tapp_pkg::INT_W-1:0]  integ_sel, integ_d;
  logic [tapp_pkg::POS_W:0]    err_wide, dif_wide, dif_abs;
  logic                        dif_neg;
  logic [tapp_pkg::QUO_W-1:0]  dividend, quotient;
  logic [tapp_pkg::POS_W-1:0]  inc;
  logic [tapp_pkg::INT_W:0]    isum;
  logic [tapp_pkg::OPD_W-1:0]  opa, opb;
  logic [tapp_pkg::ACC_W-1:0]  prod_ext;
  logic [tapp_pkg::ACC_W-tapp_pkg::FRAC_W-tapp_pkg::POS_W:0] acc_top;
  logic [tapp_pkg::DER_W-1:0]  qmag;

  assign sp_sel    = sp_q[cmd_i.axis];
  assign ms_sel    = ms_q[cmd_i.axis];
  assign prev_sel  = prev_q[cmd_i.axis];
  assign integ_sel = integ_q[cmd_i.axis];

  always_comb begin
    err_wide = {sp_sel[tapp_pkg::POS_W-1], sp_sel} - {ms_sel[tapp_pkg::POS_W-1], ms_sel};
    if (err_wide[tapp_pkg::POS_W] == err_wide[tapp_pkg::POS_W-1]) begin
      err_d = err_wide[tapp_pkg::POS_W-1:0];
    end else if (err_wide[tapp_pkg::POS_W]) begin
      err_d = tapp_pkg::POS_MIN;
    end else begin
      err_d = tapp_pkg::POS_MAX;
    end
  end

  always_comb begin
    dif_wide = {err_q[tapp_pkg::POS_W-1], err_q} - {prev_sel[tapp_pkg::POS_W-1], prev_sel};
    dif_neg  = dif_wide[tapp_pkg::POS_W];
    dif_abs  = dif_neg ? (~dif_wide + 1'b1) : dif_wide;
    dividend = {dif_abs[tapp_pkg::POS_W-1:0], {tapp_pkg::FRAC_W{1'b0}}};
  end

  tapp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (dividend),
    .divisor_i  (dt_q),
    .busy_o     (stat_o.div_busy),
    .quotient_o (quotient)
  );

  always_comb begin
    qmag = {1'b0, quotient};
    der_d = neg_q ? (~qmag + 1'b1) : qmag;
    if (dt_q == '0) begin
      der_d = '0;
    end
  end

  always_comb begin
    inc  = prod_q[tapp_pkg::FRAC_W +: tapp_pkg::POS_W];
    isum = {integ_sel[tapp_pkg::INT_W-1], integ_sel}
         + {{(tapp_pkg::INT_W+1-tapp_pkg::POS_W){inc[tapp_pkg::POS_W-1]}}, inc};
    if (isum[tapp_pkg::INT_W] == isum[tapp_pkg::INT_W-1]) begin
      integ_d = isum[tapp_pkg::INT_W-1:0];
    end else if (isum[tapp_pkg::INT_W]) begin
      integ_d = tapp_pkg::INT_MIN;
    end else begin
      integ_d = tapp_pkg::INT_MAX;
    end
  end

  always_comb begin
    opa = {ki_q[tapp_pkg::GAIN_W-1], ki_q};
    opb = {1'b0, integ_sel[tapp_pkg::SPLIT_W-1:0]};
    case (cmd_i.mul_sel)
      tapp_pkg::MUL_E_DT: begin
        opa = {err_q[tapp_pkg::POS_W-1], err_q};
        opb = {{(tapp_pkg::OPD_W-tapp_pkg::DT_W){1'b0}}, dt_q};
      end
      tapp_pkg::MUL_KP_E: begin
        opa = {kp_q[tapp_pkg::GAIN_W-1], kp_q};
        opb = {err_q[tapp_pkg::POS_W-1], err_q};
      end
      tapp_pkg::MUL_KI_ILO: begin
        opa = {ki_q[tapp_pkg::GAIN_W-1], ki_q};
        opb = {1'b0, integ_sel[tapp_pkg::SPLIT_W-1:0]};
      end
      tapp_pkg::MUL_KI_IHI: begin
        opa = {ki_q[tapp_pkg::GAIN_W-1], ki_q};
        opb = {{(tapp_pkg::OPD_W-tapp_pkg::INT_W+tapp_pkg::SPLIT_W){integ_sel[tapp_pkg::INT_W-1]}},
               integ_sel[tapp_pkg::INT_W-1:tapp_pkg::SPLIT_W]};
      end
      tapp_pkg::MUL_KD_DLO: begin
        opa = {kd_q[tapp_pkg::GAIN_W-1], kd_q};
        opb = {1'b0, der_q[tapp_pkg::SPLIT_W-1:0]};
      end
      tapp_pkg::MUL_KD_DHI: begin
        opa = {kd_q[tapp_pkg::GAIN_W-1], kd_q};
        opb = {{(tapp_pkg::OPD_W-tapp_pkg::DER_W+tapp_pkg::SPLIT_W){der_q[tapp_pkg::DER_W-1]}},
               der_q[tapp_pkg::DER_W-1:tapp_pkg::SPLIT_W]};
      end
      tapp_pkg::MUL_CTL_DT: begin
        opa = {ctl_q[tapp_pkg::POS_W-1], ctl_q};
        opb = {{(tapp_pkg::OPD_W-tapp_pkg::DT_W){1'b0}}, dt_q};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod_d = tapp_pkg::PROD_W'($signed(opa)) * tapp_pkg::PROD_W'($signed(opb));

  always_comb begin
    prod_ext = {{(tapp_pkg::ACC_W-tapp_pkg::PROD_W){prod_q[tapp_pkg::PROD_W-1]}}, prod_q};
    case (cmd_i.acc_op)
      tapp_pkg::ACC_HOLD:   acc_d = acc_q;
      tapp_pkg::ACC_CLEAR:  acc_d = '0;
      tapp_pkg::ACC_ADD_LO: acc_d = acc_q + prod_ext;
      tapp_pkg::ACC_ADD_HI: acc_d = acc_q
        + {prod_ext[tapp_pkg::ACC_W-tapp_pkg::SPLIT_W-1:0], {tapp_pkg::SPLIT_W{1'b0}}};
      default:              acc_d = acc_q;
    endcase
  end

  always_comb begin
    acc_top = acc_q[tapp_pkg::ACC_W-1:tapp_pkg::FRAC_W+tapp_pkg::POS_W-1];
    if ((&acc_top) || !(|acc_top)) begin
      ctl_d = acc_q[tapp_pkg::FRAC_W +: tapp_pkg::POS_W];
    end else if (acc_q[tapp_pkg::ACC_W-1]) begin
      ctl_d = tapp_pkg::POS_MIN;
    end else begin
      ctl_d = tapp_pkg::POS_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= '0;
      ki_q <= '0;
      kd_q <= '0;
      for (int a = 0; a < tapp_pkg::AXES; a++) begin
        integ_q[a] <= '0;
        prev_q[a]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          tapp_pkg::REG_KP: kp_q <= cfg_data_i;
          tapp_pkg::REG_KI: ki_q <= cfg_data_i;
          tapp_pkg::REG_KD: kd_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.update_state) begin
        integ_q[cmd_i.axis] <= integ_d;
        prev_q[cmd_i.axis]  <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (cmd_i.latch_in) begin
      sp_q[0] <= setpoint_x_i;
      sp_q[1] <= setpoint_y_i;
      sp_q[2] <= setpoint_z_i;
      ms_q[0] <= measured_x_i;
      ms_q[1] <= measured_y_i;
      ms_q[2] <= measured_z_i;
      dt_q    <= tick_time_i;
    end
    if (cmd_i.calc_err) begin
      err_q <= err_d;
    end
    if (cmd_i.start_div) begin
      neg_q <= dif_neg;
    end
    if (cmd_i.load_d) begin
      der_q <= der_d;
    end
    if (cmd_i.calc_ctl) begin
      ctl_q <= ctl_d;
    end
    if (cmd_i.store_res) begin
      ctl_res_q[cmd_i.axis] <= ctl_q;
      off_res_q[cmd_i.axis] <= prod_q[tapp_pkg::FRAC_W +: tapp_pkg::POS_W];
    end
    if (cmd_i.load_out) begin
      ctl_out_q <= ctl_res_q;
      off_out_q <= off_res_q;
    end
  end

  assign control_x_o = ctl_out_q[0];
  assign control_y_o = ctl_out_q[1];
  assign control_z_o = ctl_out_q[2];
  assign offset_x_o  = off_out_q[0];
  assign offset_y_o  = off_out_q[1];
  assign offset_z_o  = off_out_q[2];

endmodule

// ===== sv/tapp_ctrl.sv =====
// Controller: sequences the per-axis steps and owns the request handshakes.
module tapp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            target_present_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  tapp_pkg::stat_t stat_i,
  output tapp_pkg::cmd_t  cmd_o
);

  typedef enum logic [14:0] {
    ST_IDLE    = 15'h0001,
    ST_ERR     = 15'h0002,
    ST_MEDT    = 15'h0004,
    ST_INT     = 15'h0008,
    ST_KPA     = 15'h0010,
    ST_KIL     = 15'h0020,
    ST_KIH     = 15'h0040,
    ST_DWAIT   = 15'h0080,
    ST_KDL     = 15'h0100,
    ST_KDLA    = 15'h0200,
    ST_KDH     = 15'h0400,
    ST_CTL     = 15'h0800,
    ST_MOFF    = 15'h1000,
    ST_OFF     = 15'h2000,
    ST_PUBLISH = 15'h4000
  } state_e;

  state_e                      state_q, state_d;
  logic [tapp_pkg::AXIS_W-1:0] axis_q, axis_d;
  logic                        out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    out_valid_d = out_valid_q;
    cmd_o         = '0;
    cmd_o.mul_sel = tapp_pkg::MUL_E_DT;
    cmd_o.acc_op  = tapp_pkg::ACC_HOLD;
    cmd_o.axis    = axis_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && target_present_i) begin
          cmd_o.latch_in = 1'b1;
          axis_d         = '0;
          state_d        = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd_o.calc_err = 1'b1;
        state_d        = ST_MEDT;
      end
      ST_MEDT: begin
        cmd_o.mul_sel   = tapp_pkg::MUL_E_DT;
        cmd_o.start_div = 1'b1;
        state_d         = ST_INT;
      end
      ST_INT: begin
        cmd_o.update_state = 1'b1;
        cmd_o.mul_sel      = tapp_pkg::MUL_KP_E;
        cmd_o.acc_op       = tapp_pkg::ACC_CLEAR;
        state_d            = ST_KPA;
      end
      ST_KPA: begin
        cmd_o.acc_op  = tapp_pkg::ACC_ADD_LO;
        cmd_o.mul_sel = tapp_pkg::MUL_KI_ILO;
        state_d       = ST_KIL;
      end
      ST_KIL: begin
        cmd_o.acc_op  = tapp_pkg::ACC_ADD_LO;
        cmd_o.mul_sel = tapp_pkg::MUL_KI_IHI;
        state_d       = ST_KIH;
      end
      ST_KIH: begin
        cmd_o.acc_op = tapp_pkg::ACC_ADD_HI;
        state_d      = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.load_d = 1'b1;
          state_d      = ST_KDL;
        end
      end
      ST_KDL: begin
        cmd_o.mul_sel = tapp_pkg::MUL_KD_DLO;
        state_d       = ST_KDLA;
      end
      ST_KDLA: begin
        cmd_o.acc_op  = tapp_pkg::ACC_ADD_LO;
        cmd_o.mul_sel = tapp_pkg::MUL_KD_DHI;
        state_d       = ST_KDH;
      end
      ST_KDH: begin
        cmd_o.acc_op = tapp_pkg::ACC_ADD_HI;
        state_d      = ST_CTL;
      end
      ST_CTL: begin
        cmd_o.calc_ctl = 1'b1;
        state_d        = ST_MOFF;
      end
      ST_MOFF: begin
        cmd_o.mul_sel = tapp_pkg::MUL_CTL_DT;
        state_d       = ST_OFF;
      end
      ST_OFF: begin
        cmd_o.store_res = 1'b1;
        if (axis_q == tapp_pkg::LAST_AXIS) begin
          state_d = ST_PUBLISH;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = ST_ERR;
        end
      end
      ST_PUBLISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/three_axis_position_pid_top.sv =====
// Top level of the three-axis PID position controller.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------------
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in_valid_i/in_ready_o   | target_present, setpoint_*, measured_*, tick_time
//   out     | out_valid_o/out_ready_i | control_*, offset_*
//
// A request with a target passes an accept step, the per-axis steps, which wait on the
// bit-serial divider for the derivative term, and a publish step.
// A request without a target is taken and gives no result.
// Reset clears the gains, the integrals and the previous errors.
// The output register holds a result under a stall while the next request is
// accepted and worked; a finished request waits only for that register to free up.
module three_axis_position_pid_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tapp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tapp_pkg::GAIN_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              target_present_i,
  input  logic signed [tapp_pkg::POS_W-1:0] setpoint_x_i,
  input  logic signed [tapp_pkg::POS_W-1:0] setpoint_y_i,
  input  logic signed [tapp_pkg::POS_W-1:0] setpoint_z_i,
  input  logic signed [tapp_pkg::POS_W-1:0] measured_x_i,
  input  logic signed [tapp_pkg::POS_W-1:0] measured_y_i,
  input  logic signed [tapp_pkg::POS_W-1:0] measured_z_i,
  input  logic [tapp_pkg::DT_W-1:0]         tick_time_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [tapp_pkg::POS_W-1:0] control_x_o,
  output logic signed [tapp_pkg::POS_W-1:0] control_y_o,
  output logic signed [tapp_pkg::POS_W-1:0] control_z_o,
  output logic signed [tapp_pkg::POS_W-1:0] offset_x_o,
  output logic signed [tapp_pkg::POS_W-1:0] offset_y_o,
  output logic signed [tapp_pkg::POS_W-1:0] offset_z_o
);

  tapp_pkg::cmd_t  cmd;
  tapp_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  tapp_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .target_present_i (target_present_i),
    .in_ready_o       (in_ready_o),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .stat_i           (stat),
    .cmd_o            (cmd)
  );

  tapp_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .setpoint_x_i (setpoint_x_i),
    .setpoint_y_i (setpoint_y_i),
    .setpoint_z_i (setpoint_z_i),
    .measured_x_i (measured_x_i),
    .measured_y_i (measured_y_i),
    .measured_z_i (measured_z_i),
    .tick_time_i  (tick_time_i),
    .control_x_o  (control_x_o),
    .control_y_o  (control_y_o),
    .control_z_o  (control_z_o),
    .offset_x_o   (offset_x_o),
    .offset_y_o   (offset_y_o),
    .offset_z_o   (offset_z_o)
  );

endmodule

// ===== sv/tapp_chk.sv =====
// Port-level checker for the three-axis PID controller, bound to the top level.
`include "assert_macros.svh"

module tapp_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              target_present_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [tapp_pkg::POS_W-1:0] control_x_o,
  input logic signed [tapp_pkg::POS_W-1:0] control_y_o,
  input logic signed [tapp_pkg::POS_W-1:0] control_z_o,
  input logic signed [tapp_pkg::POS_W-1:0] offset_x_o,
  input logic signed [tapp_pkg::POS_W-1:0] offset_y_o,
  input logic signed [tapp_pkg::POS_W-1:0] offset_z_o
);

  logic req_take;
  logic sign_x_ok, sign_y_ok, sign_z_ok;

  assign req_take  = in_valid_i && in_ready_o;
  assign sign_x_ok = (offset_x_o == '0) ||
                     (offset_x_o[tapp_pkg::POS_W-1] == control_x_o[tapp_pkg::POS_W-1]);
  assign sign_y_ok = (offset_y_o == '0) ||
                     (offset_y_o[tapp_pkg::POS_W-1] == control_y_o[tapp_pkg::POS_W-1]);
  assign sign_z_ok = (offset_z_o == '0) ||
                     (offset_z_o[tapp_pkg::POS_W-1] == control_z_o[tapp_pkg::POS_W-1]);

  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(control_x_o))

  `ASSERT_NEXT(a_skip_silent, !out_valid_o && req_take && !target_present_i, !out_valid_o)

  `ASSERT_NEXT(a_busy_after_take, req_take && target_present_i, !in_ready_o)

  `ASSERT_SAME(a_publish_to_idle, $rose(out_valid_o), in_ready_o)

  `ASSERT_SAME(a_offset_sign, out_valid_o, sign_x_ok && sign_y_ok && sign_z_ok)

endmodule

bind three_axis_position_pid_top tapp_chk u_chk (.*);

// ===== test/testbench.sv =====
// Directed and randomized checks of the three-axis PID controller against a bit-exact predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [tapp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [tapp_pkg::GAIN_W-1:0] GAIN_MAX = 32'h7FFF_FFFF;
  localparam logic [tapp_pkg::GAIN_W-1:0] GAIN_MIN = 32'h8000_0000;
  localparam logic [tapp_pkg::GAIN_W-1:0] GAIN_ONE = 32'h0001_0000;
  localparam longint ERR_MAX = 64'sd2147483647;
  localparam longint ERR_MIN = -64'sd2147483648;
  localparam longint SUM_MAX = (64'sd1 <<< 47) - 64'sd1;
  localparam longint SUM_MIN = -(64'sd1 <<< 47);
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_AT = 40;
  localparam int HOLD_CYCLES = 1200;
  localparam int PHASES = 6;
  localparam int PER_PHASE = 84;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic                                         present;
    logic [tapp_pkg::AXES-1:0][tapp_pkg::POS_W-1:0] setpoint;
    logic [tapp_pkg::AXES-1:0][tapp_pkg::POS_W-1:0] measured;
    logic [tapp_pkg::DT_W-1:0]                    tick;
  } pid_req_t;

  typedef struct packed {
    logic [tapp_pkg::AXES-1:0][tapp_pkg::POS_W-1:0] control;
    logic [tapp_pkg::AXES-1:0][tapp_pkg::POS_W-1:0] offset;
  } pid_res_t;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [tapp_pkg::CFG_IDX_W-1:0] idx;
    logic [tapp_pkg::GAIN_W-1:0]    data;
    pid_req_t                       req;
    logic                           typed;
    pid_res_t                       res;
  } stim_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_e;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [tapp_pkg::CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [tapp_pkg::GAIN_W-1:0]       cfg_data_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic                              target_present_i = 1'b0;
  logic signed [tapp_pkg::POS_W-1:0] setpoint_x_i = '0;
  logic signed [tapp_pkg::POS_W-1:0] setpoint_y_i = '0;
  logic signed [tapp_pkg::POS_W-1:0] setpoint_z_i = '0;
  logic signed [tapp_pkg::POS_W-1:0] measured_x_i = '0;
  logic signed [tapp_pkg::POS_W-1:0] measured_y_i = '0;
  logic signed [tapp_pkg::POS_W-1:0] measured_z_i = '0;
  logic [tapp_pkg::DT_W-1:0]         tick_time_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic signed [tapp_pkg::POS_W-1:0] control_x_o;
  logic signed [tapp_pkg::POS_W-1:0] control_y_o;
  logic signed [tapp_pkg::POS_W-1:0] control_z_o;
  logic signed [tapp_pkg::POS_W-1:0] offset_x_o;
  logic signed [tapp_pkg::POS_W-1:0] offset_y_o;
  logic signed [tapp_pkg::POS_W-1:0] offset_z_o;

  logic signed [tapp_pkg::GAIN_W-1:0] gain_p = '0;
  logic signed [tapp_pkg::GAIN_W-1:0] gain_i = '0;
  logic signed [tapp_pkg::GAIN_W-1:0] gain_d = '0;
  longint integ_q [tapp_pkg::AXES];
  longint last_err [tapp_pkg::AXES];

  pid_res_t  control_due [$];
  stim_row_t tick_script [$];
  int        error_count = 0;
  int        burst_left = 0;

  int       rx_seen = 0;
  int       hold_left = 0;
  logic     hold_done = 1'b0;
  int       seg_left = 0;
  rx_mode_e rx_mode = RX_OPEN;

  three_axis_position_pid_top dut (.*);

  always #10 clk_i = ~clk_i;

  function automatic pid_res_t pid_update(input pid_req_t r);
    pid_res_t res;
    longint dt, e, sum_i, der, ctl, ofs;
    logic signed [127:0] acc, w_e, w_i, w_d, g_p, g_i, g_d;
    dt = longint'(r.tick);
    g_p = gain_p;
    g_i = gain_i;
    g_d = gain_d;
    for (int a = 0; a < tapp_pkg::AXES; a++) begin
      e = longint'($signed(r.setpoint[a])) - longint'($signed(r.measured[a]));
      if (e > ERR_MAX) e = ERR_MAX;
      else if (e < ERR_MIN) e = ERR_MIN;
      sum_i = integ_q[a] + ((e * dt) >>> 16);
      if (sum_i > SUM_MAX) sum_i = SUM_MAX;
      else if (sum_i < SUM_MIN) sum_i = SUM_MIN;
      integ_q[a] = sum_i;
      der = (dt != 0) ? ((e - last_err[a]) * 64'sd65536) / dt : 64'sd0;
      last_err[a] = e;
      w_e = e;
      w_i = sum_i;
      w_d = der;
      acc = (g_p * w_e + g_i * w_i + g_d * w_d) >>> 16;
      if (acc > ERR_MAX) ctl = ERR_MAX;
      else if (acc < ERR_MIN) ctl = ERR_MIN;
      else ctl = acc[63:0];
      ofs = (ctl * dt) >>> 16;
      res.control[a] = ctl[31:0];
      res.offset[a] = ofs[31:0];
    end
    return res;
  endfunction

  function automatic void gain_write(input logic [tapp_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [tapp_pkg::GAIN_W-1:0] val);
    case (idx)
      tapp_pkg::REG_KP: gain_p = val;
      tapp_pkg::REG_KI: gain_i = val;
      tapp_pkg::REG_KD: gain_d = val;
      default: ;
    endcase
  endfunction

  function automatic logic [tapp_pkg::GAIN_W-1:0] pick_gain(input int phase);
    int kind;
    if (phase == 0) kind = 0;
    else if (phase == PHASES - 1) kind = $urandom_range(2, 3);
    else kind = $urandom_range(0, 5);
    case (kind)
      0: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      1: return $urandom;
      2: return GAIN_MAX;
      3: return GAIN_MIN;
      4: return '0;
      default: return GAIN_ONE;
    endcase
  endfunction

  function automatic pid_req_t rand_req();
    pid_req_t r;
    int pick;
    r.present = ($urandom_range(0, 5) != 0);
    for (int a = 0; a < tapp_pkg::AXES; a++) begin
      r.setpoint[a] = $urandom;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        r.measured[a] = r.setpoint[a] + $urandom_range(0, 8191) - 4096;
      end else if (pick < 8) begin
        r.measured[a] = $urandom;
      end else if (pick == 8) begin
        r.setpoint[a] = $urandom_range(0, 1) ? tapp_pkg::POS_MAX : tapp_pkg::POS_MIN;
        r.measured[a] = ~r.setpoint[a];
      end else begin
        r.measured[a] = r.setpoint[a];
      end
    end
    pick = $urandom_range(0, 9);
    if (pick < 6) r.tick = tapp_pkg::DT_W'($urandom_range(1, 65535));
    else if (pick == 6) r.tick = tapp_pkg::DT_W'($urandom_range(1, 16));
    else if (pick == 7) r.tick = 16'hFFFF;
    else if (pick == 8) r.tick = '0;
    else r.tick = tapp_pkg::DT_W'($urandom_range(256, 4096));
    return r;
  endfunction

  function automatic void add_cfg(input logic [tapp_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [tapp_pkg::GAIN_W-1:0] val);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.data = val;
    tick_script.push_back(row);
  endfunction

  function automatic void add_req(input logic present,
                                  input logic [tapp_pkg::POS_W-1:0] sp,
                                  input logic [tapp_pkg::POS_W-1:0] ms,
                                  input logic [tapp_pkg::DT_W-1:0] dt,
                                  input logic typed, input logic [tapp_pkg::POS_W-1:0] ctl,
                                  input logic [tapp_pkg::POS_W-1:0] ofs);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REQ;
    row.req.present = present;
    row.req.tick = dt;
    row.typed = typed;
    for (int a = 0; a < tapp_pkg::AXES; a++) begin
      row.req.setpoint[a] = sp;
      row.req.measured[a] = ms;
      row.res.control[a] = ctl;
      row.res.offset[a] = ofs;
    end
    tick_script.push_back(row);
  endfunction

  function automatic void flag_error(input string what,
                                     input logic [tapp_pkg::POS_W-1:0] want,
                                     input logic [tapp_pkg::POS_W-1:0] got);
    if (error_count < REPORT_MAX)
      $display("%0t: mismatch %s: expected %h, got %h", $time, what, want, got);
    error_count++;
  endfunction

  task automatic cfg_write(input logic [tapp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tapp_pkg::GAIN_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    gain_write(idx, val);
  endtask

  task automatic send_req(input pid_req_t r, input logic typed, input pid_res_t typed_res);
    int gap;
    pid_res_t res;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 250) : $urandom_range(1, 4);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_present_i <= r.present;
    setpoint_x_i <= r.setpoint[0];
    setpoint_y_i <= r.setpoint[1];
    setpoint_z_i <= r.setpoint[2];
    measured_x_i <= r.measured[0];
    measured_y_i <= r.measured[1];
    measured_z_i <= r.measured[2];
    tick_time_i <= r.tick;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (r.present) begin
      res = pid_update(r);
      if (typed) res = typed_res;
      control_due.push_back(res);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (control_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    pid_res_t want;
    pid_res_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.control = {control_z_o, control_y_o, control_x_o};
      got.offset = {offset_z_o, offset_y_o, offset_x_o};
      if (control_due.size() == 0) begin
        flag_error("result with no request pending", '0, got.control[0]);
      end else begin
        want = control_due.pop_front();
        for (int a = 0; a < tapp_pkg::AXES; a++) begin
          if (want.control[a] !== got.control[a])
            flag_error($sformatf("control axis %0d", a), want.control[a], got.control[a]);
          if (want.offset[a] !== got.offset[a])
            flag_error($sformatf("offset axis %0d", a), want.offset[a], got.offset[a]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) rx_seen <= rx_seen + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (!hold_done && rx_seen >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left <= $urandom_range(20, 200);
          rx_mode <= rx_mode_e'($urandom_range(0, 2));
        end else begin
          seg_left <= seg_left - 1;
        end
        case (rx_mode)
          RX_OPEN: out_ready_i <= 1'b1;
          RX_RANDOM: out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= (seg_left % 16 == 0);
        endcase
      end
    end
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    pid_req_t r;
    int sent;
    for (int a = 0; a < tapp_pkg::AXES; a++) begin
      integ_q[a] = 0;
      last_err[a] = 0;
    end

    // zero gains after reset, including saturated error and zero tick time
    add_req(1'b1, tapp_pkg::POS_MAX, tapp_pkg::POS_MIN, 16'hFFFF, 1'b1, '0, '0);
    add_req(1'b1, tapp_pkg::POS_MIN, tapp_pkg::POS_MAX, 16'h0001, 1'b1, '0, '0);
    add_req(1'b0, 32'h1234_5678, 32'h0000_0000, 16'h0100, 1'b0, '0, '0);
    add_req(1'b1, 32'h0000_1000, 32'h0000_0000, 16'h0000, 1'b1, '0, '0);
    add_cfg(REG_UNUSED, GAIN_MAX);
    add_req(1'b1, 32'h0000_0100, 32'hFFFF_FF00, 16'h8000, 1'b1, '0, '0);
    // proportional extremes saturate the control
    add_cfg(tapp_pkg::REG_KP, GAIN_MAX);
    add_req(1'b1, tapp_pkg::POS_MAX, tapp_pkg::POS_MIN, 16'hFFFF, 1'b1,
            tapp_pkg::POS_MAX, 32'h7FFF_7FFF);
    add_req(1'b1, tapp_pkg::POS_MIN, tapp_pkg::POS_MAX, 16'hFFFF, 1'b1,
            tapp_pkg::POS_MIN, 32'h8000_8000);
    add_req(1'b1, tapp_pkg::POS_MAX, tapp_pkg::POS_MAX, 16'hFFFF, 1'b1, '0, '0);
    add_cfg(tapp_pkg::REG_KP, GAIN_MIN);
    add_req(1'b1, tapp_pkg::POS_MAX, tapp_pkg::POS_MIN, 16'hFFFF, 1'b1,
            tapp_pkg::POS_MIN, 32'h8000_8000);
    add_req(1'b1, tapp_pkg::POS_MIN, tapp_pkg::POS_MAX, 16'hFFFF, 1'b1,
            tapp_pkg::POS_MAX, 32'h7FFF_7FFF);
    add_cfg(tapp_pkg::REG_KP, GAIN_ONE);
    add_cfg(tapp_pkg::REG_KI, GAIN_MAX);
    add_cfg(tapp_pkg::REG_KD, GAIN_MIN);
    add_req(1'b1, 32'h0000_0500, 32'h0000_0100, 16'h0001, 1'b0, '0, '0);
    add_req(1'b1, 32'hFFFF_F000, 32'h0000_0100, 16'h0000, 1'b0, '0, '0);
    add_req(1'b0, tapp_pkg::POS_MAX, tapp_pkg::POS_MIN, 16'h0000, 1'b0, '0, '0);
    add_req(1'b1, 32'h0001_0000, 32'h0000_8000, 16'hFFFF, 1'b0, '0, '0);
    add_cfg(tapp_pkg::REG_KI, GAIN_ONE);
    add_cfg(tapp_pkg::REG_KD, GAIN_ONE);
    add_req(1'b1, tapp_pkg::POS_MIN, 32'h0000_0000, 16'h0010, 1'b0, '0, '0);
    add_req(1'b1, 32'h0000_0000, tapp_pkg::POS_MIN, 16'h7FFF, 1'b0, '0, '0);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (tick_script[i]) begin
      if (tick_script[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(tick_script[i].idx, tick_script[i].data);
      end else begin
        send_req(tick_script[i].req, tick_script[i].typed, tick_script[i].res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      cfg_write(tapp_pkg::REG_KP, pick_gain(p));
      cfg_write(tapp_pkg::REG_KI, pick_gain(p));
      cfg_write(tapp_pkg::REG_KD, pick_gain(p));
      cfg_write(REG_UNUSED, $urandom);
      sent = 0;
      while (sent < PER_PHASE) begin
        r = rand_req();
        send_req(r, 1'b0, '0);
        sent++;
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/tapp_pkg.sv
sv/tapp_div.sv
sv/tapp_dpath.sv
sv/tapp_ctrl.sv
sv/three_axis_position_pid_top.sv
sv/tapp_chk.sv
test/testbench.sv
